@@ design/assert_macros.svh @@
// assertion macros for the rtl of the systematic resampler
// no dependencies; included by systematic_resampler.sv, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

@@ design/sysres_pkg.sv @@
// field widths, register indexes and reset values of the systematic resampler
// no dependencies; imported by systematic_resampler and the testbench
`default_nettype none

package sysres_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int PAYLOAD_W  = 64;
   localparam int OFFSET_W   = 16;
   localparam int ANC_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int STEP_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] REG_PARTICLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_STEP     = 2'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd1024;

endpackage

`default_nettype wire

@@ design/systematic_resampler.sv @@
// systematic resampler top level: particle stores, walk sequencer, output register
// depends on sysres_pkg and assert_macros.svh
`default_nettype none

// Systematic resampling for a particle filter. Particles arrive one per
// transfer on the req_ channel (weight, payload) and are written into two
// on-chip stores at consecutive slots; a transfer with req_last set ends the
// load, supplies the start point req_offset and starts the walk. The walk
// compares the running weight sum against the points offset + n*point_step
// (saturating, WEIGHT_BITS fraction bits) and sends one rsp_ transfer per
// point n = 0..N-1 with the chosen ancestor index and its payload;
// rsp_final_res marks the last one. N is particle_count clamped to
// 1..MAX_PARTICLES. Particles beyond MAX_PARTICLES are dropped.
// Timing: loading takes one item per cycle. After the last item req_stall
// stays high for the whole walk: ST_FIRST, ST_SEED, then ST_CMP and ST_EMIT
// per point with ST_SAMPLE between points, and ST_ACC, ST_CMP once more per
// ancestor advance (at most N-1), as a single saturating adder serves sum,
// point and step updates in turn and the stores are read through a register.
// Result backpressure on rsp_stall adds its stall cycles. The csr_ port is
// always ready and is meant to be written only while the block is idle.

`include "assert_macros.svh"

module systematic_resampler
   import sysres_pkg::*;
#(
   parameter int MAX_PARTICLES = 64,
   parameter int PAYLOAD_BITS  = 64,
   parameter int WEIGHT_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // particle load channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [WEIGHT_W-1:0]   req_weight,
   input  wire logic [PAYLOAD_W-1:0]  req_payload,
   input  wire logic [OFFSET_W-1:0]   req_offset,
   input  wire logic                  req_last,
   // resampled particle channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ANC_W-1:0]           rsp_ancestor,
   output logic [PAYLOAD_W-1:0]       rsp_chosen_payload,
   output logic                       rsp_final_res,
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // index width, sum width and the usable bits of each narrowed operand
   localparam int AW  = $clog2(MAX_PARTICLES);
   localparam int SW  = WEIGHT_BITS + 1;
   localparam int WST = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam int RW  = (SW < OFFSET_W) ? SW : OFFSET_W;
   localparam int PW  = (SW < STEP_W) ? SW : STEP_W;
   localparam logic [AW:0]        LOAD_FULL = (AW+1)'(MAX_PARTICLES);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PARTICLES);

   typedef enum logic [2:0] {
      ST_LOAD,    // taking particles
      ST_FIRST,   // read slot 0
      ST_SEED,    // sum from slot 0, first sample point
      ST_CMP,     // compare point against sum
      ST_ACC,     // add newly read weight into the sum
      ST_EMIT,    // hand result to the output register
      ST_SAMPLE   // next sample point from the step product
   } state_type;

   // particle stores, contents undefined until written
   logic [WST-1:0]          weight_mem [MAX_PARTICLES];
   logic [PAYLOAD_BITS-1:0] payload_mem [MAX_PARTICLES];
   logic [WST-1:0]          weight_rd_ff;
   logic [PAYLOAD_BITS-1:0] payload_rd_ff;

   // configuration
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // sequencer and walk state
   state_type       state_ff, state_in;
   logic [AW:0]     load_ff, load_in;
   logic [AW-1:0]   anc_ff, anc_in;
   logic [AW-1:0]   emit_ff, emit_in;
   logic [SW-1:0]   sum_ff, sum_in;
   logic [SW-1:0]   point_ff, point_in;
   logic [SW-1:0]   prod_ff, prod_in;
   logic [SW-1:0]   start_ff, start_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [AW-1:0]        out_anc_ff, out_anc_in;
   logic [PAYLOAD_W-1:0] out_pay_ff, out_pay_in;
   logic                 out_final_ff, out_final_in;

   // shared saturating adder
   logic [SW-1:0] add_a, add_b, add_sat;
   logic [SW:0]   add_full;

   logic               req_xfer;
   logic               store_wr;
   logic               out_free;
   logic [COUNT_W-1:0] n_res;
   logic [AW-1:0]      limit;
   logic [SW-1:0]      weight_ext;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign store_wr  = req_xfer && (load_ff < LOAD_FULL);
   assign out_free  = !out_valid_ff || !rsp_stall;

   // number of results, clamped to the store depth
   always_comb begin
      if (count_ff == '0) begin
         n_res = COUNT_W'(1);
      end else if (count_ff > MAX_COUNT) begin
         n_res = MAX_COUNT;
      end else begin
         n_res = count_ff;
      end
   end
   assign limit = AW'(n_res - COUNT_W'(1));

   assign weight_ext = SW'(weight_rd_ff);

   // operand selection for the one adder, saturating at all ones
   always_comb begin
      case (state_ff)
         ST_SEED, ST_SAMPLE: begin
            add_a = start_ff;
            add_b = prod_ff;
         end
         ST_ACC: begin
            add_a = sum_ff;
            add_b = weight_ext;
         end
         ST_EMIT: begin
            add_a = prod_ff;
            add_b = SW'(step_ff[PW-1:0]);
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end
   assign add_full = {1'b0, add_a} + {1'b0, add_b};
   assign add_sat  = add_full[SW] ? {SW{1'b1}} : add_full[SW-1:0];

   // stores: one write port for loading, one registered read at the next ancestor
   always_ff @(posedge clock) begin
      if (store_wr) begin
         weight_mem[load_ff[AW-1:0]]  <= req_weight[WST-1:0];
         payload_mem[load_ff[AW-1:0]] <= req_payload[PAYLOAD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      weight_rd_ff  <= weight_mem[anc_in];
      payload_rd_ff <= payload_mem[anc_in];
   end

   // next state of the sequencer
   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      anc_in       = anc_ff;
      emit_in      = emit_ff;
      sum_in       = sum_ff;
      point_in     = point_ff;
      prod_in      = prod_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_anc_in   = out_anc_ff;
      out_pay_in   = out_pay_ff;
      out_final_in = out_final_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PARTICLE_COUNT: count_in = csr_data[COUNT_W-1:0];
            REG_POINT_STEP:     step_in  = csr_data[STEP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (store_wr) begin
                  load_in = load_ff + (AW+1)'(1);
               end
               if (req_last) begin
                  // start a round: first point is the offset itself
                  load_in  = '0;
                  anc_in   = '0;
                  emit_in  = '0;
                  prod_in  = '0;
                  start_in = SW'(req_offset[RW-1:0]);
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            // slot 0 may have been written on the previous edge, read it now
            state_in = ST_SEED;
         end
         ST_SEED: begin
            sum_in   = weight_ext;
            point_in = add_sat;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((point_ff > sum_ff) && (anc_ff < limit)) begin
               anc_in   = anc_ff + AW'(1);
               state_in = ST_ACC;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_ACC: begin
            sum_in   = add_sat;
            state_in = ST_CMP;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_anc_in   = anc_ff;
               out_pay_in   = PAYLOAD_W'(payload_rd_ff);
               out_final_in = (emit_ff == limit);
               if (emit_ff == limit) begin
                  state_in = ST_LOAD;
               end else begin
                  // step product advances while the result leaves
                  prod_in  = add_sat;
                  emit_in  = emit_ff + AW'(1);
                  state_in = ST_SAMPLE;
               end
            end
         end
         ST_SAMPLE: begin
            point_in = add_sat;
            state_in = ST_CMP;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_ff      <= '0;
         anc_ff       <= '0;
         emit_ff      <= '0;
         sum_ff       <= '0;
         point_ff     <= '0;
         count_ff     <= COUNT_RESET;
         step_ff      <= STEP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         anc_ff       <= anc_in;
         emit_ff      <= emit_in;
         sum_ff       <= sum_in;
         point_ff     <= point_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff      <= prod_in;
      start_ff     <= start_in;
      out_anc_ff   <= out_anc_in;
      out_pay_ff   <= out_pay_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_ancestor       = ANC_W'(out_anc_ff);
   assign rsp_chosen_payload = out_pay_ff;
   assign rsp_final_res      = out_final_ff;

   // walk never points past the last result slot
   `ASSERT_AT(a_anc_in_range, clock, reset, (state_ff == ST_LOAD) || (anc_ff <= limit), "ancestor beyond limit during walk")
   // a shown result never names an ancestor past the limit
   `ASSERT_AT(a_rsp_in_range, clock, reset, !rsp_valid || (out_anc_ff <= limit), "result ancestor beyond limit")
   // the closing load transfer always starts a walk
   `ASSERT_AT(a_last_starts, clock, reset, !(req_xfer && req_last) || (state_in == ST_FIRST), "last transfer did not start the walk")
   // emit counter never runs past the final slot
   `ASSERT_NEVER(a_emit_over, clock, reset, (state_ff != ST_LOAD) && (emit_ff > limit), "emit index beyond limit")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for the systematic resampler: random particle loads,
// register settings and handshake idling, every result checked in order
// depends on sysres_pkg and systematic_resampler

module testbench;
   import sysres_pkg::*;

   localparam int SLOTS = 64;                       // particle store depth of the block
   localparam int ONE = 65536;                      // 1.0 in the sum format
   localparam longint unsigned SUM_MAX = 64'h1FFFF; // saturation value of sums and points
   localparam int RANDOM_ITEMS = 380;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3; // index with no register behind it

   typedef enum {W_NORMAL, W_RANDOM, W_ZERO, W_FULL, W_SPARSE} weight_shape_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0]  weight;
      logic [PAYLOAD_W-1:0] payload;
      logic [OFFSET_W-1:0]  offset;
      logic                 last;
   } particle_type;

   typedef struct packed {
      logic [ANC_W-1:0]     ancestor;
      logic [PAYLOAD_W-1:0] payload;
      logic                 final_res;
   } draw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [WEIGHT_W-1:0]   req_weight = '0;
   logic [PAYLOAD_W-1:0]  req_payload = '0;
   logic [OFFSET_W-1:0]   req_offset = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ANC_W-1:0]      rsp_ancestor;
   logic [PAYLOAD_W-1:0]  rsp_chosen_payload;
   logic                  rsp_final_res;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // particles waiting to be driven, and draws the block still owes us
   particle_type particle_q[$];
   draw_type     resampled_q[$];

   // shadow of the block: stores, fill pointer and register copies
   logic [WEIGHT_W-1:0]  weight_mem [SLOTS];
   logic [PAYLOAD_W-1:0] payload_mem [SLOTS];
   int                   fill_idx = 0;
   logic [COUNT_W-1:0]   cfg_count = COUNT_RESET;
   logic [STEP_W-1:0]    cfg_step = STEP_RESET;

   int errors = 0;
   int particles_sent = 0;
   int rounds_done = 0;
   int draws_seen = 0;

   // idle percentages per side, changed between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap = 0;
   int recv_gap = 0;

   // stimulus bookkeeping: store entries 0..written_hi-1 hold data
   int written_hi = 0;
   int made = 0;

   systematic_resampler uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_weight         (req_weight),
      .req_payload        (req_payload),
      .req_offset         (req_offset),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ancestor       (rsp_ancestor),
      .rsp_chosen_payload (rsp_chosen_payload),
      .rsp_final_res      (rsp_final_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned clamp_sum(input longint unsigned v);
      return (v > SUM_MAX) ? SUM_MAX : v;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   // the systematic walk: point n sits at start + n*step, the ancestor moves on
   // while the point lies above the running sum, but never past N-1
   task automatic resample_walk(input logic [OFFSET_W-1:0] start);
      int              n_res;
      int              anc;
      longint unsigned acc;
      longint unsigned point;
      draw_type        d;
      n_res = int'(cfg_count);
      if (n_res == 0) n_res = 1;
      if (n_res > SLOTS) n_res = SLOTS;
      anc = 0;
      acc = 64'(weight_mem[0]);
      for (int n = 0; n < n_res; n++) begin
         point = clamp_sum(longint'(start) + clamp_sum(longint'(n) * longint'(cfg_step)));
         while (point > acc && anc < n_res - 1) begin
            anc++;
            acc = clamp_sum(acc + weight_mem[anc]);
         end
         d.ancestor = anc[ANC_W-1:0];
         d.payload = payload_mem[anc];
         d.final_res = (n == n_res - 1);
         resampled_q.push_back(d);
      end
   endtask

   // one accepted particle: store it while there is room, run the walk on last
   task automatic absorb_particle(input particle_type p);
      if (fill_idx < SLOTS) begin
         weight_mem[fill_idx] = p.weight;
         payload_mem[fill_idx] = p.payload;
         fill_idx++;
      end
      if (p.last) begin
         resample_walk(p.offset);
         fill_idx = 0;
         rounds_done++;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: feeds req_ from particle_q, holds the payload while stalled,
   // inserts random idle bursts independent of req_stall
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_particles
      particle_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (particle_q.size() > 0) begin
            if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
               // valid low now and through a random idle burst after
               send_gap = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else begin
               nxt = particle_q.pop_front();
               req_weight <= nxt.weight;
               req_payload <= nxt.payload;
               req_offset <= nxt.offset;
               req_last <= nxt.last;
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks each rsp_ transfer against the oldest expected draw,
   // then feeds each req_ transfer of the same edge to the shadow model,
   // and drives rsp_stall in random bursts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      draw_type     want;
      particle_type took;
      logic         stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            draws_seen++;
            if (resampled_q.size() == 0) begin
               errors++;
               $error("result with nothing expected: ancestor %0d payload %h final_res %0b",
                      rsp_ancestor, rsp_chosen_payload, rsp_final_res);
            end else begin
               want = resampled_q.pop_front();
               if (rsp_ancestor !== want.ancestor) begin
                  errors++;
                  $error("ancestor: expected %0d, got %0d", want.ancestor, rsp_ancestor);
               end
               if (rsp_chosen_payload !== want.payload) begin
                  errors++;
                  $error("chosen_payload: expected %h, got %h", want.payload,
                         rsp_chosen_payload);
               end
               if (rsp_final_res !== want.final_res) begin
                  errors++;
                  $error("final_res: expected %0b, got %0b", want.final_res, rsp_final_res);
               end
            end
         end
         if (req_valid && !req_stall) begin
            took.weight = req_weight;
            took.payload = req_payload;
            took.offset = req_offset;
            took.last = req_last;
            absorb_particle(took);
            particles_sent++;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            stall_next = 1'b1;
         end else if (recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
            recv_gap = $urandom_range(0, 9);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_particle(input logic [WEIGHT_W-1:0] w, input logic [PAYLOAD_W-1:0] p,
                                input logic [OFFSET_W-1:0] ofs, input bit last);
      particle_type it;
      it.weight = w;
      it.payload = p;
      it.offset = ofs;
      it.last = last;
      particle_q.push_back(it);
      made++;
   endtask

   // a load of k particles with last on the final one; offset of the last
   // lies inside the first step unless any_offset asks for the full range
   task automatic push_round(input int k, input weight_shape_type shape, input bit any_offset);
      int                  left;
      int                  w;
      int                  top;
      logic [OFFSET_W-1:0] ofs;
      left = ONE;
      if (cfg_step == 0) top = 0;
      else if (int'(cfg_step) > ONE) top = ONE - 1;
      else top = int'(cfg_step) - 1;
      ofs = any_offset ? OFFSET_W'($urandom_range(0, ONE - 1))
                       : OFFSET_W'($urandom_range(0, top));
      for (int i = 0; i < k; i++) begin
         case (shape)
            W_NORMAL: begin
               // weights add up to one (one lsb less if the last is capped), split at random
               if (i == k - 1) w = left;
               else w = $urandom_range(0, 2 * left / (k - i));
               if (w > ONE - 1) w = ONE - 1;
               left -= w;
            end
            W_RANDOM: w = $urandom_range(0, ONE - 1);
            W_ZERO:   w = 0;
            W_FULL:   w = ONE - 1;
            default: begin
               w = ($urandom_range(0, 7) == 0) ? $urandom_range(8192, ONE - 1) : 0;
            end
         endcase
         push_particle(w[WEIGHT_W-1:0], rand_payload(),
                       (i == k - 1) ? ofs : OFFSET_W'($urandom_range(0, ONE - 1)), i == k - 1);
      end
      if (k > written_hi) written_hi = (k > SLOTS) ? SLOTS : k;
   endtask

   // register write; the block must be idle, so the shadow copy follows at once
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_PARTICLE_COUNT) cfg_count = val[COUNT_W-1:0];
      else if (idx == REG_POINT_STEP) cfg_step = val[STEP_W-1:0];
   endtask

   // sender holds off until every expected draw is in, then a short settle
   task automatic wait_drained();
      do @(negedge clock);
      while (particle_q.size() != 0 || req_valid || resampled_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      int start_made;
      int sel;
      int cnt;
      int n_eff;
      int stp;
      int k;
      int n_rounds;
      weight_shape_type shape;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: single particle rounds at the field extremes
      write_reg(REG_PARTICLE_COUNT, 17'd1);
      write_reg(REG_POINT_STEP, 17'd65535);
      push_particle(16'hFFFF, {PAYLOAD_W{1'b1}}, 16'hFFFF, 1'b1);
      push_particle(16'h0000, {PAYLOAD_W{1'b0}}, 16'h0000, 1'b1);
      written_hi = 1;
      wait_drained();

      // directed: four particles, even weights, then all mass on the last one,
      // then zero weights so the walk runs into its ancestor ceiling,
      // then fewer particles loaded than results
      write_reg(REG_PARTICLE_COUNT, 17'd4);
      write_reg(REG_POINT_STEP, 17'd16384);
      for (int i = 0; i < 4; i++) push_particle(16'd16384, rand_payload(), 16'd0, i == 3);
      for (int i = 0; i < 4; i++)
         push_particle((i == 3) ? 16'hFFFF : 16'd0, rand_payload(), 16'd16383, i == 3);
      written_hi = 4;
      push_round(4, W_ZERO, 1'b0);
      push_round(2, W_RANDOM, 1'b0);
      wait_drained();

      // directed: count zero acts as one, zero step
      write_reg(REG_PARTICLE_COUNT, 17'd0);
      write_reg(REG_POINT_STEP, 17'd0);
      push_round(1, W_RANDOM, 1'b1);
      wait_drained();

      // directed: largest step, sample points saturate from the second point on
      write_reg(REG_PARTICLE_COUNT, 17'd3);
      write_reg(REG_POINT_STEP, 17'h1FFFF);
      push_round(3, W_RANDOM, 1'b1);
      wait_drained();

      // directed: a write to the unused index changes nothing
      write_reg(REG_SPARE, 17'h15A5A);
      write_reg(REG_PARTICLE_COUNT, 17'd2);
      write_reg(REG_POINT_STEP, 17'd32768);
      push_round(2, W_NORMAL, 1'b0);
      wait_drained();

      // count above the store size clamps to 64; a 66 particle load
      // overflows the store and fills every entry
      start_made = made;
      send_idle_pct = 20;
      recv_idle_pct = 20;
      write_reg(REG_PARTICLE_COUNT, 17'd127);
      write_reg(REG_POINT_STEP, 17'd1024);
      push_round(66, W_NORMAL, 1'b0);
      wait_drained();

      // random phases: mostly well formed rounds with 1/N step, some broken
      while (made < start_made + RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) cnt = 0;
         else if (sel == 1) cnt = $urandom_range(65, 127);
         else if (sel < 13) cnt = $urandom_range(1, 12);
         else if (sel < 18) cnt = $urandom_range(13, 40);
         else cnt = $urandom_range(41, 64);
         n_eff = (cnt == 0) ? 1 : ((cnt > SLOTS) ? SLOTS : cnt);

         sel = $urandom_range(0, 9);
         if (sel < 7) stp = ONE / n_eff;
         else if (sel == 7) stp = $urandom_range(0, 131071);
         else if (sel == 8) stp = ($urandom_range(0, 1) == 1) ? 131071 : 0;
         else stp = ONE / n_eff + $urandom_range(0, 64);

         write_reg(REG_PARTICLE_COUNT, CSR_DATA_W'(cnt));
         write_reg(REG_POINT_STEP, CSR_DATA_W'(stp));

         // idle mix per phase, including phases with no idling at all
         sel = $urandom_range(0, 2);
         send_idle_pct = (sel == 0) ? 0 : ((sel == 1) ? 10 : 35);
         sel = $urandom_range(0, 2);
         recv_idle_pct = (sel == 0) ? 0 : ((sel == 1) ? 10 : 35);

         n_rounds = $urandom_range(1, 4);
         for (int r = 0; r < n_rounds; r++) begin
            sel = $urandom_range(0, 19);
            if (sel < 15) k = n_eff;
            else if (sel < 18) k = $urandom_range(1, n_eff);
            else if (sel == 18) k = n_eff + $urandom_range(1, 3);
            else k = $urandom_range(65, 68);
            // the walk may read up to entry N-1, which must hold data
            if (k < n_eff && written_hi < n_eff) k = n_eff;
            sel = $urandom_range(0, 9);
            if (sel < 6) shape = W_NORMAL;
            else if (sel == 6) shape = W_RANDOM;
            else if (sel == 7) shape = W_ZERO;
            else if (sel == 8) shape = W_FULL;
            else shape = W_SPARSE;
            push_round(k, shape, $urandom_range(0, 5) == 0);
         end
         wait_drained();
      end

      // closing stretch without any idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_PARTICLE_COUNT, 17'd16);
      write_reg(REG_POINT_STEP, 17'd4096);
      push_round(16, W_NORMAL, 1'b0);
      push_round(16, W_RANDOM, 1'b0);
      wait_drained();
      repeat (40) @(posedge clock);

      $display("covered %0d particle transfers in %0d resampling rounds, %0d results checked",
               particles_sent, rounds_done, draws_seen);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #20000000;
      $display("timeout with %0d results outstanding", resampled_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/sysres_pkg.sv
design/systematic_resampler.sv
tb/sv/testbench.sv
